[hw/rtl/oaht_pkg.sv]
// Shared types and constants of the open-addressing hash table unit.
`default_nettype none

package oaht_pkg;

  localparam int SLOTS     = 256;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int LIVE_W    = 9;
  localparam int WORD_W    = 32;
  localparam int LIMIT_W   = 7;
  localparam int LOAD_W    = CNT_W + LIMIT_W;
  localparam int ENTRY_W   = 3 * WORD_W;
  localparam int PADDR_W   = 2;
  localparam int PDATA_W   = 32;
  localparam int PCT_SCALE = 100;

  localparam logic [PADDR_W-1:0] LOAD_LIMIT_ADDR = PADDR_W'(0);

  localparam logic [WORD_W-1:0]  MARK_REMOVED = WORD_W'(1);
  localparam logic [WORD_W-1:0]  FIRST_VALID  = WORD_W'(2);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(70);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] hash_code;
    logic [WORD_W-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] value_out;
    logic [LIVE_W-1:0] live_count;
  } out_item_t;

endpackage

`default_nettype wire

[hw/rtl/oaht_ram.sv]
// Generic single-port RAM with a registered read.
`default_nettype none

module oaht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[hw/rtl/open_addressing_hash_table_unit.sv]
// Top level of the open-addressing key/value table with triangular probing.
// The table holds SLOTS entries of hash, key and value in one single-port RAM, with one
// occupancy flip-flop per slot so that reset and the clear operation empty every slot at
// once. An item is taken only while the sequencer is idle. Each probe has two steps,
// one to read the slot and one to compare and possibly write it back; clear and a
// refused insert skip the probe steps and go straight to the response. The probe path
// starts at hash mod SLOTS, hash codes below 2 raised by 2 first, and steps by 1, 2, 3
// and so on, for at most SLOTS probes; SLOTS must be a power of two. The load limit
// register sits at byte address 0 and is written with an APB access.
`default_nettype none

module open_addressing_hash_table_unit
  import oaht_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [PADDR_W-1:0] cfg_paddr,
  input  wire logic [PDATA_W-1:0] cfg_pwdata,
  output logic      [PDATA_W-1:0] cfg_prdata,
  output logic                    cfg_pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_RESP
  } state_t;

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [WORD_W-1:0]  key_r, key_nxt;
  logic [WORD_W-1:0]  hash_r, hash_nxt;
  logic [WORD_W-1:0]  value_r, value_nxt;
  logic [SLOT_W-1:0]  pos_r, pos_nxt;
  logic [SLOT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]   live_r, live_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [SLOTS-1:0]   slot_vld_r, slot_vld_nxt;
  logic               vld_q_r, vld_q_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [WORD_W-1:0]  res_value_r, res_value_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [WORD_W-1:0]  rd_hash;
  logic [WORD_W-1:0]  rd_key;
  logic [WORD_W-1:0]  rd_value;
  logic [WORD_W-1:0]  hash_adj;
  logic [LOAD_W-1:0]  load_need;
  logic [LOAD_W-1:0]  load_cap;
  logic               load_full;
  logic               is_empty;
  logic               is_removed;
  logic               is_match;
  logic               last_probe;
  logic               cfg_write;

  oaht_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (pos_r),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign rd_hash  = ram_rdata[3*WORD_W-1:2*WORD_W];
  assign rd_key   = ram_rdata[2*WORD_W-1:WORD_W];
  assign rd_value = ram_rdata[WORD_W-1:0];

  assign hash_adj   = (in_data.hash_code < FIRST_VALID) ? in_data.hash_code + FIRST_VALID
                                                        : in_data.hash_code;
  assign load_need  = (LOAD_W'(used_r) + LOAD_W'(1)) * LOAD_W'(PCT_SCALE);
  assign load_cap   = LOAD_W'(SLOTS) * LOAD_W'(limit_r);
  assign load_full  = load_need >= load_cap;

  assign is_empty   = !vld_q_r;
  assign is_removed = vld_q_r && (rd_hash == MARK_REMOVED);
  assign is_match   = vld_q_r && (rd_hash == hash_r) && (rd_key == key_r);
  assign last_probe = n_r == SLOT_W'(SLOTS - 1);

  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == LOAD_LIMIT_ADDR);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = PDATA_W'(limit_r);

  assign in_ready   = state_r == S_IDLE;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    hash_nxt       = hash_r;
    value_nxt      = value_r;
    pos_nxt        = pos_r;
    n_nxt          = n_r;
    live_nxt       = live_r;
    used_nxt       = used_r;
    limit_nxt      = cfg_write ? cfg_pwdata[LIMIT_W-1:0] : limit_r;
    slot_vld_nxt   = slot_vld_r;
    vld_q_nxt      = vld_q_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_wdata      = {hash_r, key_r, value_r};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_data.op;
          key_nxt        = in_data.key;
          hash_nxt       = hash_adj;
          value_nxt      = in_data.value_in;
          pos_nxt        = hash_adj[SLOT_W-1:0];
          n_nxt          = '0;
          res_status_nxt = ST_OK;
          res_value_nxt  = '0;
          state_nxt      = S_READ;
          if (in_data.op == OP_CLEAR) begin
            slot_vld_nxt = '0;
            live_nxt     = '0;
            used_nxt     = '0;
            state_nxt    = S_RESP;
          end else if (in_data.op == OP_INSERT && load_full) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_RESP;
          end
        end
      end
      S_READ: begin
        vld_q_nxt = slot_vld_r[pos_r];
        state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_RESP;
        case (op_r)
          OP_INSERT: begin
            if (is_empty || is_removed) begin
              ram_we              = 1'b1;
              slot_vld_nxt[pos_r] = 1'b1;
              live_nxt            = live_r + CNT_W'(1);
              if (is_empty) begin
                used_nxt = used_r + CNT_W'(1);
              end
            end else if (last_probe) begin
              res_status_nxt = ST_FULL;
            end else begin
              state_nxt = S_READ;
            end
          end
          OP_REMOVE, OP_LOOKUP: begin
            if (is_empty) begin
              res_status_nxt = ST_MISSING;
            end else if (is_match) begin
              if (op_r == OP_REMOVE) begin
                ram_we    = 1'b1;
                ram_wdata = {MARK_REMOVED, rd_key, rd_value};
                live_nxt  = live_r - CNT_W'(1);
              end else begin
                res_value_nxt = rd_value;
              end
            end else if (last_probe) begin
              res_status_nxt = ST_MISSING;
            end else begin
              state_nxt = S_READ;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
        if (state_nxt == S_READ) begin
          pos_nxt = pos_r + n_r + SLOT_W'(1);
          n_nxt   = n_r + SLOT_W'(1);
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = res_status_r;
          out_data_nxt.value_out  = res_value_r;
          out_data_nxt.live_count = LIVE_W'(live_r);
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    hash_r       <= hash_nxt;
    value_r      <= value_nxt;
    pos_r        <= pos_nxt;
    n_r          <= n_nxt;
    vld_q_r      <= vld_q_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_data_r   <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      used_r      <= '0;
      limit_r     <= LIMIT_RESET;
      slot_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      used_r      <= used_nxt;
      limit_r     <= limit_nxt;
      slot_vld_r  <= slot_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Live entries never exceed occupied slots, tombstones included.
  a_live_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= used_r)
    else $error("live entry count exceeds used slot count");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op == OP_CLEAR |=> live_r == '0 && used_r == '0 &&
      slot_vld_r == '0)
    else $error("clear did not empty the table");

  a_write_in_compare: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_CMP && op_r != OP_LOOKUP)
    else $error("slot RAM written outside a compare step");

  a_probe_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op != OP_CLEAR |=> n_r == '0)
    else $error("probe counter not restarted on a new transfer");

  a_result_after_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RESP)
    else $error("result presented without passing the response step");

endmodule

`default_nettype wire
